>>> hw/rtl/pse_pkg.sv
// pse_pkg: shared types, constants and codes of the particle swarm update engine.
// Used by pse_scale, pse_core, particle_swarm_update_engine and pse_checker; depends on nothing.
package pse_pkg;

	localparam int DEF_MAX_DIMS      = 32;
	localparam int DEF_MAX_PARTICLES = 32;
	localparam int VALUE_WIDTH       = 32;
	localparam int OPW               = 41;
	localparam int MULW              = 16;
	localparam int REG_AW            = 5;

	localparam logic signed [VALUE_WIDTH-1:0] RES_MAX = 32'sh7FFF_FFFF;

	localparam logic [2:0] MODE_INIT    = 3'd0;
	localparam logic [2:0] MODE_UPDATE  = 3'd1;
	localparam logic [2:0] MODE_RESIDUE = 3'd2;
	localparam logic [2:0] MODE_READ    = 3'd3;
	localparam logic [2:0] MODE_SPREAD  = 3'd4;

	localparam logic [2:0] REG_PHI_P     = 3'd0;
	localparam logic [2:0] REG_PHI_G     = 3'd1;
	localparam logic [2:0] REG_KAPPA     = 3'd2;
	localparam logic [2:0] REG_DIMS      = 3'd3;
	localparam logic [2:0] REG_PARTICLES = 3'd4;
	localparam logic [2:0] REG_THRESHOLD = 3'd5;

	typedef enum logic [0:0] {
		SH_16,
		SH_12
	} shift_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_UPD_DP,
		ST_UPD_TP,
		ST_UPD_DG,
		ST_UPD_TG,
		ST_UPD_V,
		ST_UPD_CLAMP,
		ST_UPD_WB,
		ST_COPY,
		ST_SPREAD,
		ST_SP_W1,
		ST_SP_W2,
		ST_SP_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] phi_personal;
		logic [15:0] phi_global;
		logic [12:0] constriction;
		logic [5:0]  active_dims;
		logic [5:0]  active_particles;
		logic [31:0] spread_threshold;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [4:0]         particle;
		logic [4:0]         dim;
		logic signed [31:0] init_position;
		logic signed [31:0] init_velocity;
		logic [30:0]        velocity_limit;
		logic [15:0]        rand_personal;
		logic [15:0]        rand_global;
		logic signed [31:0] residue;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic signed [31:0] global_best_residue;
		logic               improved_personal;
		logic               improved_global;
		logic [31:0]        spread;
		logic               converged;
	} result_t;

endpackage

>>> hw/rtl/pse_ram.sv
// pse_ram: single-port-write, single-port-read memory with registered read data.
// Depends on nothing; instantiated by pse_core for the swarm stores.
module pse_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int W     = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rd_data_q
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

endmodule

>>> hw/rtl/pse_scale.sv
// pse_scale: shared multiply-and-round unit, round(a * m / 2^s) ties away from zero.
// Product registered, then rounding and sign applied combinationally. Uses pse_pkg.
module pse_scale
	import pse_pkg::*;
(
	input  logic                  clk,
	input  logic signed [OPW-1:0] a,
	input  logic [MULW-1:0]       m,
	input  shift_t                sh,
	output logic signed [OPW-1:0] y
);

	localparam int PW = OPW + MULW;
	localparam logic [PW-1:0] HALF16 = PW'(1) << 15;
	localparam logic [PW-1:0] HALF12 = PW'(1) << 11;

	logic [OPW-1:0] mag;
	logic [PW-1:0]  prod_s1;
	logic           neg_s1;
	shift_t         sh_s1;
	logic [PW-1:0]  rnd;

	always_comb begin
		mag = a[OPW-1] ? OPW'(-a) : OPW'(a);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(mag) * PW'(m);
		neg_s1  <= a[OPW-1];
		sh_s1   <= sh;
	end

	always_comb begin
		if (sh_s1 == SH_16) begin
			rnd = (prod_s1 + HALF16) >> 16;
		end else begin
			rnd = (prod_s1 + HALF12) >> 12;
		end
		y = neg_s1 ? -$signed(OPW'(rnd)) : $signed(OPW'(rnd));
	end

endmodule

>>> hw/rtl/pse_core.sv
// pse_core: sequencer, swarm stores and datapath of the engine.
// Uses pse_pkg, pse_ram for the position, velocity and personal-best stores, pse_scale.
module pse_core
	import pse_pkg::*;
#(
	parameter int MAX_DIMS      = DEF_MAX_DIMS,
	parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    start,
	input  item_t   item,
	output logic    idle,
	output logic    done,
	output result_t res
);

	localparam int DEPTH = MAX_DIMS * MAX_PARTICLES;
	localparam int DW    = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
	localparam int PW    = MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CWD   = $clog2(MAX_DIMS + 1);
	localparam int CWP   = $clog2(MAX_PARTICLES + 1);
	localparam int ACCW  = 32 + CWD;

	state_t state_q, nxt;
	item_t  it_q;
	result_t res_q;

	logic [8:0]     nd9, np9;
	logic [CWD-1:0] nd;
	logic [CWP-1:0] np;
	logic           p_ok, d_ok;
	logic [DW-1:0]  d_idx;
	logic [PW-1:0]  p_idx;
	logic [AW-1:0]  row, k, row_q;

	logic signed [31:0] gb_q [MAX_DIMS];
	logic [30:0]        lim_q [MAX_DIMS];
	logic signed [31:0] pres_q [MAX_PARTICLES];
	logic signed [31:0] gbv_q;

	logic           pos_we, vel_we, pb_we;
	logic [AW-1:0]  pos_waddr, pos_raddr, pb_waddr;
	logic [31:0]    pos_wdata, vel_wdata;
	logic [31:0]    pos_rd, vel_rd, pb_rd;

	logic signed [OPW-1:0] ua, uy;
	logic [MULW-1:0]       um;
	shift_t                ush;

	logic signed [31:0]    pos_q, vel_q, v_q;
	logic signed [OPW-1:0] tp_q, lim_s, vclamp;
	logic signed [32:0]    newpos;
	logic signed [31:0]    newpos_sat;

	logic           imp_p_c, imp_g_c, imp_p_q, imp_g_q;
	logic [CWD-1:0] cnt_q;
	logic [DW-1:0]  cpj_q;

	logic [CWD-1:0]     sj_q;
	logic [CWP-1:0]     si_q;
	logic               last_i, last_j;
	logic               sp_vld_s1, sp_first_s1, sp_last_s1;
	logic signed [31:0] mn_q, mx_q, nmn, nmx, x;
	logic [32:0]        diff_s2;
	logic               diff_vld_s2;
	logic [ACCW-1:0]    acc_q;
	logic [31:0]        spread_sat;

	always_comb begin
		nd9 = 9'(cfg.active_dims);
		np9 = 9'(cfg.active_particles);
		if (nd9 == 9'd0) begin
			nd9 = 9'd1;
		end else if (nd9 > 9'(MAX_DIMS)) begin
			nd9 = 9'(MAX_DIMS);
		end
		if (np9 == 9'd0) begin
			np9 = 9'd1;
		end else if (np9 > 9'(MAX_PARTICLES)) begin
			np9 = 9'(MAX_PARTICLES);
		end
		nd    = CWD'(nd9);
		np    = CWP'(np9);
		p_ok  = 9'(it_q.particle) < np9;
		d_ok  = 9'(it_q.dim) < nd9;
		d_idx = DW'(it_q.dim);
		p_idx = PW'(it_q.particle);
		row   = AW'(it_q.particle) * AW'(MAX_DIMS);
		k     = row + AW'(it_q.dim);
		imp_p_c = it_q.residue < pres_q[p_idx];
		imp_g_c = it_q.residue < gbv_q;
		lim_s   = $signed(OPW'(lim_q[d_idx]));
		x       = $signed(pos_rd);
		last_i  = si_q == np - CWP'(1);
		last_j  = sj_q == nd - CWD'(1);
	end

	pse_ram #(.DEPTH(DEPTH), .AW(AW), .W(32)) u_pos (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(pos_raddr), .rd_data_q(pos_rd)
	);

	pse_ram #(.DEPTH(DEPTH), .AW(AW), .W(32)) u_vel (
		.clk(clk), .we(vel_we), .waddr(k), .wdata(vel_wdata),
		.raddr(k), .rd_data_q(vel_rd)
	);

	pse_ram #(.DEPTH(DEPTH), .AW(AW), .W(32)) u_pbest (
		.clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pos_rd),
		.raddr(k), .rd_data_q(pb_rd)
	);

	pse_scale u_scale (.clk(clk), .a(ua), .m(um), .sh(ush), .y(uy));

	always_comb begin
		vclamp = uy;
		if (uy > lim_s) begin
			vclamp = lim_s;
		end else if (uy < -lim_s) begin
			vclamp = -lim_s;
		end
		newpos = 33'(pos_q) + 33'(v_q);
		if (newpos > 33'sh0_7FFF_FFFF) begin
			newpos_sat = 32'sh7FFF_FFFF;
		end else if (newpos < -33'sh0_8000_0000) begin
			newpos_sat = 32'sh8000_0000;
		end else begin
			newpos_sat = 32'(newpos);
		end
		nmn = (sp_first_s1 || x < mn_q) ? x : mn_q;
		nmx = (sp_first_s1 || x > mx_q) ? x : mx_q;
		spread_sat = (acc_q > ACCW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : acc_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		nxt       = state_q;
		idle      = 1'b0;
		done      = 1'b0;
		pos_we    = 1'b0;
		vel_we    = 1'b0;
		pb_we     = 1'b0;
		pos_waddr = k;
		pos_wdata = it_q.init_position;
		vel_wdata = it_q.init_velocity;
		pos_raddr = k;
		pb_waddr  = row_q + AW'(cpj_q);
		ua        = OPW'($signed(pb_rd)) - OPW'($signed(pos_rd));
		um        = it_q.rand_personal;
		ush       = SH_16;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					nxt = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				nxt = ST_DONE;
				case (it_q.mode)
					MODE_INIT: begin
						if (p_ok && d_ok) begin
							pos_we = 1'b1;
							vel_we = 1'b1;
						end
					end
					MODE_UPDATE: begin
						if (p_ok && d_ok) begin
							nxt = ST_UPD_DP;
						end
					end
					MODE_RESIDUE: begin
						if (p_ok && (imp_p_c || imp_g_c)) begin
							nxt = ST_COPY;
						end
					end
					MODE_SPREAD: begin
						nxt = ST_SPREAD;
					end
					default: begin
						nxt = ST_DONE;
					end
				endcase
			end
			ST_UPD_DP: begin
				nxt = ST_UPD_TP;
			end
			ST_UPD_TP: begin
				ua  = uy;
				um  = cfg.phi_personal;
				ush = SH_12;
				nxt = ST_UPD_DG;
			end
			ST_UPD_DG: begin
				ua  = OPW'(gb_q[d_idx]) - OPW'(pos_q);
				um  = it_q.rand_global;
				nxt = ST_UPD_TG;
			end
			ST_UPD_TG: begin
				ua  = uy;
				um  = cfg.phi_global;
				ush = SH_12;
				nxt = ST_UPD_V;
			end
			ST_UPD_V: begin
				ua  = OPW'(vel_q) + tp_q + uy;
				um  = MULW'(cfg.constriction);
				ush = SH_12;
				nxt = ST_UPD_CLAMP;
			end
			ST_UPD_CLAMP: begin
				nxt = ST_UPD_WB;
			end
			ST_UPD_WB: begin
				pos_we    = 1'b1;
				vel_we    = 1'b1;
				pos_wdata = newpos_sat;
				vel_wdata = v_q;
				nxt       = ST_DONE;
			end
			ST_COPY: begin
				pos_raddr = row_q + AW'(cnt_q);
				pb_we     = imp_p_q && (cnt_q != CWD'(0));
				if (cnt_q == CWD'(MAX_DIMS)) begin
					nxt = ST_DONE;
				end
			end
			ST_SPREAD: begin
				pos_raddr = AW'(si_q) * AW'(MAX_DIMS) + AW'(sj_q);
				if (last_i && last_j) begin
					nxt = ST_SP_W1;
				end
			end
			ST_SP_W1: begin
				nxt = ST_SP_W2;
			end
			ST_SP_W2: begin
				nxt = ST_SP_FIN;
			end
			ST_SP_FIN: begin
				nxt = ST_DONE;
			end
			ST_DONE: begin
				done = 1'b1;
				nxt  = ST_IDLE;
			end
			default: begin
				nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbv_q       <= RES_MAX;
			sp_vld_s1   <= 1'b0;
			diff_vld_s2 <= 1'b0;
			for (int i = 0; i < MAX_PARTICLES; i++) begin
				pres_q[i] <= RES_MAX;
			end
		end else begin
			sp_vld_s1   <= state_q == ST_SPREAD;
			diff_vld_s2 <= sp_vld_s1 && sp_last_s1;
			if (state_q == ST_DISPATCH) begin
				if (it_q.mode == MODE_INIT && p_ok && d_ok) begin
					pres_q[p_idx] <= RES_MAX;
					if (it_q.particle == 5'd0 && it_q.dim == 5'd0) begin
						gbv_q <= RES_MAX;
					end
				end
				if (it_q.mode == MODE_RESIDUE && p_ok) begin
					if (imp_p_c) begin
						pres_q[p_idx] <= it_q.residue;
					end
					if (imp_g_c) begin
						gbv_q <= it_q.residue;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			it_q <= item;
		end
		sp_first_s1 <= si_q == CWP'(0);
		sp_last_s1  <= last_i;
		case (state_q)
			ST_DISPATCH: begin
				res_q.value_out <= (it_q.mode == MODE_READ && d_ok) ? gb_q[d_idx] : '0;
				res_q.global_best_residue <= '0;
				res_q.improved_personal <= (it_q.mode == MODE_RESIDUE) && p_ok && imp_p_c;
				res_q.improved_global   <= (it_q.mode == MODE_RESIDUE) && p_ok && imp_g_c;
				res_q.spread    <= '0;
				res_q.converged <= 1'b0;
				row_q   <= row;
				cnt_q   <= '0;
				sj_q    <= '0;
				si_q    <= '0;
				acc_q   <= '0;
				imp_p_q <= imp_p_c;
				imp_g_q <= imp_g_c;
				if (it_q.mode == MODE_INIT && p_ok && d_ok) begin
					lim_q[d_idx] <= it_q.velocity_limit;
				end
			end
			ST_UPD_DP: begin
				pos_q <= $signed(pos_rd);
				vel_q <= $signed(vel_rd);
			end
			ST_UPD_DG: begin
				tp_q <= uy;
			end
			ST_UPD_CLAMP: begin
				v_q <= 32'(vclamp);
			end
			ST_UPD_WB: begin
				res_q.value_out <= newpos_sat;
			end
			ST_COPY: begin
				cnt_q <= cnt_q + CWD'(1);
				cpj_q <= DW'(cnt_q);
				if (imp_g_q && cnt_q != CWD'(0)) begin
					gb_q[cpj_q] <= $signed(pos_rd);
				end
			end
			ST_SPREAD: begin
				if (last_i) begin
					si_q <= '0;
					sj_q <= sj_q + CWD'(1);
				end else begin
					si_q <= si_q + CWP'(1);
				end
			end
			ST_SP_FIN: begin
				res_q.spread    <= spread_sat;
				res_q.converged <= spread_sat < cfg.spread_threshold;
			end
			default: begin
			end
		endcase
		if (sp_vld_s1) begin
			mn_q <= nmn;
			mx_q <= nmx;
			if (sp_last_s1) begin
				diff_s2 <= 33'(nmx) - 33'(nmn);
			end
		end
		if (diff_vld_s2) begin
			acc_q <= acc_q + ACCW'(diff_s2);
		end
	end

	always_comb begin
		res = res_q;
		res.global_best_residue = gbv_q;
	end

endmodule

>>> hw/rtl/particle_swarm_update_engine.sv
// particle_swarm_update_engine: top level with stream ports, APB registers, result register.
// Uses pse_pkg and pse_core.
//
//   channel  | direction | payload                          | handshake
//   s_axis   | in        | tuser mode, tdata item fields    | tvalid/tready
//   m_axis   | out       | tdata result fields              | tvalid/tready
//   apb      | in/out    | six config registers at 4*i      | psel/penable, pready=1
//
// Init, read, unknown mode and residue without improvement: dispatch, done, then the result register.
// Update: five passes through the shared multiply-round unit, then clamp and write-back.
// Residue with improvement: one dimension of the position row copied per cycle, all MAX_DIMS.
// Spread: dims*particles positions, one position read per cycle from the single read port.
// One transaction in flight; s_axis_tready stays low until the result is taken.
// Reset loads config defaults, maxes best residues, clears control; stores start undefined.
module particle_swarm_update_engine
	import pse_pkg::*;
#(
	parameter int MAX_DIMS      = DEF_MAX_DIMS,
	parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// particle, dim, init_position, init_velocity, velocity_limit,
	// rand_personal, rand_global, residue
	input  logic [175:0]      s_axis_tdata,
	// mode
	input  logic [2:0]        s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// value_out, global_best_residue, improved_personal, improved_global,
	// spread, converged
	output logic [103:0]      m_axis_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [REG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t    cfg_q;
	item_t   item;
	result_t res;
	logic    core_idle, core_done, start;
	logic    out_vld_q;
	logic [103:0] out_data_q;
	logic [2:0]   ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phi_personal     <= 16'd11469;
			cfg_q.phi_global       <= 16'd5325;
			cfg_q.constriction     <= 13'd2989;
			cfg_q.active_dims      <= 6'd32;
			cfg_q.active_particles <= 6'd30;
			cfg_q.spread_threshold <= 32'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				REG_PHI_P:     cfg_q.phi_personal     <= pwdata[15:0];
				REG_PHI_G:     cfg_q.phi_global       <= pwdata[15:0];
				REG_KAPPA:     cfg_q.constriction     <= pwdata[12:0];
				REG_DIMS:      cfg_q.active_dims      <= pwdata[5:0];
				REG_PARTICLES: cfg_q.active_particles <= pwdata[5:0];
				REG_THRESHOLD: cfg_q.spread_threshold <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_PHI_P:     prdata = 32'(cfg_q.phi_personal);
			REG_PHI_G:     prdata = 32'(cfg_q.phi_global);
			REG_KAPPA:     prdata = 32'(cfg_q.constriction);
			REG_DIMS:      prdata = 32'(cfg_q.active_dims);
			REG_PARTICLES: prdata = 32'(cfg_q.active_particles);
			REG_THRESHOLD: prdata = cfg_q.spread_threshold;
			default:       prdata = 32'd0;
		endcase
	end

	always_comb begin
		item.mode           = s_axis_tuser;
		item.particle       = s_axis_tdata[4:0];
		item.dim            = s_axis_tdata[9:5];
		item.init_position  = $signed(s_axis_tdata[41:10]);
		item.init_velocity  = $signed(s_axis_tdata[73:42]);
		item.velocity_limit = s_axis_tdata[104:74];
		item.rand_personal  = s_axis_tdata[120:105];
		item.rand_global    = s_axis_tdata[136:121];
		item.residue        = $signed(s_axis_tdata[168:137]);
	end

	assign s_axis_tready = core_idle && !out_vld_q;
	assign start         = s_axis_tvalid && s_axis_tready;

	pse_core #(
		.MAX_DIMS(MAX_DIMS),
		.MAX_PARTICLES(MAX_PARTICLES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.start(start),
		.item(item),
		.idle(core_idle),
		.done(core_done),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (core_done) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			out_data_q <= {5'd0, res.converged, res.spread, res.improved_global,
				res.improved_personal, res.global_best_residue, res.value_out};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

>>> hw/rtl/pse_checker.sv
// pse_checker: port-level assertions for particle_swarm_update_engine, bound to the top.
// Imports pse_pkg but uses none of its contents.
module pse_checker
	import pse_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [103:0]      m_axis_tdata,
	input logic              pready
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a transaction was in flight");

	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("ready while a result waits");

	a_residue_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[64] || m_axis_tdata[65]) |->
		m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[97:66] == 32'd0 && !m_axis_tdata[98])
		else $error("improvement flag with nonzero value or spread");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind particle_swarm_update_engine pse_checker u_pse_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.pready(pready)
);

>>> tb/sv/tb_particle_swarm_update_engine.sv
// Testbench for particle_swarm_update_engine: directed and random stream items checked
// against an in-bench swarm predictor, with APB register phases. Depends on pse_pkg and the RTL.
module tb_particle_swarm_update_engine;
	import pse_pkg::*;

	localparam int ND_MAX = DEF_MAX_DIMS;
	localparam int NP_MAX = DEF_MAX_PARTICLES;
	localparam int WATCHDOG_LIMIT = 20000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [175:0]      s_axis_tdata = '0;
	logic [2:0]        s_axis_tuser = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [103:0]      m_axis_tdata;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [REG_AW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	particle_swarm_update_engine DUT (.*);

	// swarm predictor state
	longint swarm_pos[ND_MAX*NP_MAX];
	longint swarm_vel[ND_MAX*NP_MAX];
	longint pbest_pos[ND_MAX*NP_MAX];
	longint gbest_pos[ND_MAX];
	longint vel_limit[ND_MAX];
	bit     pos_known[ND_MAX*NP_MAX];
	bit     pbest_known[ND_MAX*NP_MAX];
	bit     gbest_known[ND_MAX];
	bit     limit_known[ND_MAX];
	int     pbest_res[NP_MAX];
	int     gbest_res;
	int unsigned cfg_phi_p = 11469, cfg_phi_g = 5325, cfg_kappa = 2989;
	int unsigned cfg_dims = 32, cfg_parts = 30, cfg_thresh = 1;

	result_t expected_results[$];
	int      mismatches = 0;
	int      mode_count[8];
	bit      quiet = 1'b0;
	int      m_stall = 0;
	int      idle_cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint scale_round(longint a, longint m, int s);
		longint unsigned mag, lo, r;
		mag = (a < 0) ? longint'(-a) : a;
		lo = mag & ((64'd1 << s) - 1);
		r = (mag >> s) * m + ((lo * m + (64'd1 << (s - 1))) >> s);
		return (a < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic int unsigned eff_count(int unsigned v, int unsigned maxv);
		if (v == 0) return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic result_t swarm_step(item_t it);
		result_t res;
		int unsigned nd, np, k, i, j;
		longint pos, tp, tg, v, mn, mx, x;
		longint unsigned sum;
		bit p_ok, d_ok;
		res = '0;
		nd = eff_count(cfg_dims, ND_MAX);
		np = eff_count(cfg_parts, NP_MAX);
		p_ok = it.particle < np;
		d_ok = it.dim < nd;
		k = it.particle * ND_MAX + it.dim;
		if (it.mode == MODE_INIT && p_ok && d_ok) begin
			swarm_pos[k] = longint'(it.init_position);
			swarm_vel[k] = longint'(it.init_velocity);
			pos_known[k] = 1'b1;
			vel_limit[it.dim] = longint'(it.velocity_limit);
			limit_known[it.dim] = 1'b1;
			pbest_res[it.particle] = RES_MAX;
			if (it.particle == 0 && it.dim == 0) gbest_res = RES_MAX;
		end else if (it.mode == MODE_UPDATE && p_ok && d_ok) begin
			pos = swarm_pos[k];
			tp = scale_round(scale_round(pbest_pos[k] - pos, it.rand_personal, 16),
				cfg_phi_p, 12);
			tg = scale_round(scale_round(gbest_pos[it.dim] - pos, it.rand_global, 16),
				cfg_phi_g, 12);
			v = scale_round(swarm_vel[k] + tp + tg, cfg_kappa, 12);
			if (v > vel_limit[it.dim]) v = vel_limit[it.dim];
			if (v < -vel_limit[it.dim]) v = -vel_limit[it.dim];
			v = sat32(v);
			swarm_vel[k] = v;
			swarm_pos[k] = sat32(pos + v);
			res.value_out = 32'(swarm_pos[k]);
		end else if (it.mode == MODE_RESIDUE && p_ok) begin
			if (it.residue < pbest_res[it.particle]) begin
				pbest_res[it.particle] = it.residue;
				for (j = 0; j < ND_MAX; j++) begin
					pbest_pos[it.particle*ND_MAX+j] = swarm_pos[it.particle*ND_MAX+j];
					pbest_known[it.particle*ND_MAX+j] = pos_known[it.particle*ND_MAX+j];
				end
				res.improved_personal = 1'b1;
			end
			if (it.residue < gbest_res) begin
				gbest_res = it.residue;
				for (j = 0; j < ND_MAX; j++) begin
					gbest_pos[j] = swarm_pos[it.particle*ND_MAX+j];
					gbest_known[j] = pos_known[it.particle*ND_MAX+j];
				end
				res.improved_global = 1'b1;
			end
		end else if (it.mode == MODE_READ && d_ok) begin
			res.value_out = 32'(gbest_pos[it.dim]);
		end else if (it.mode == MODE_SPREAD) begin
			sum = 0;
			for (j = 0; j < nd; j++) begin
				mn = swarm_pos[j];
				mx = swarm_pos[j];
				for (i = 1; i < np; i++) begin
					x = swarm_pos[i*ND_MAX+j];
					if (x < mn) mn = x;
					if (x > mx) mx = x;
				end
				sum += longint'(mx - mn);
			end
			if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
			res.spread = 32'(sum);
			res.converged = sum < cfg_thresh;
		end
		res.global_best_residue = gbest_res;
		return res;
	endfunction

	// replace an item that would read a never-written entry by one that fills it
	function automatic item_t make_legal(item_t it);
		int unsigned nd, np, k, i, j;
		nd = eff_count(cfg_dims, ND_MAX);
		np = eff_count(cfg_parts, NP_MAX);
		k = it.particle * ND_MAX + it.dim;
		if (it.mode == MODE_UPDATE && it.particle < np && it.dim < nd) begin
			if (!pos_known[k] || !limit_known[it.dim])
				it.mode = MODE_INIT;
			else if (!pbest_known[k] || !gbest_known[it.dim]) begin
				it.mode = MODE_RESIDUE;
				it.residue = gbest_res - 1;
				if (it.residue >= pbest_res[it.particle]) it.residue = pbest_res[it.particle] - 1;
			end
		end else if (it.mode == MODE_READ && it.dim < nd && !gbest_known[it.dim]) begin
			it.mode = MODE_INIT;
			it.particle = 0;
			for (i = 0; i < np; i++)
				if (pos_known[i*ND_MAX+it.dim]) begin
					it.mode = MODE_RESIDUE;
					it.particle = 5'(i);
					it.residue = -32'sd2147483648;
				end
			if (it.mode == MODE_RESIDUE && pbest_res[it.particle] == -32'sd2147483648 &&
				gbest_res == -32'sd2147483648)
				it.mode = MODE_INIT;
		end else if (it.mode == MODE_SPREAD) begin
			for (j = 0; j < nd; j++)
				for (i = 0; i < np; i++)
					if (!pos_known[i*ND_MAX+j] && it.mode == MODE_SPREAD) begin
						it.mode = MODE_INIT;
						it.particle = 5'(i);
						it.dim = 5'(j);
					end
		end
		return it;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return 32'($urandom_range(0, 2**21) - 2**20);
		endcase
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int unsigned sel, np, nd;
		np = eff_count(cfg_parts, NP_MAX);
		nd = eff_count(cfg_dims, ND_MAX);
		sel = $urandom_range(0, 99);
		it.mode = (sel < 20) ? MODE_INIT : (sel < 60) ? MODE_UPDATE :
			(sel < 80) ? MODE_RESIDUE : (sel < 88) ? MODE_READ :
			(sel < 94) ? MODE_SPREAD : 3'($urandom_range(0, 7));
		it.particle = ($urandom_range(0, 15) == 0) ? 5'($urandom) : 5'($urandom_range(0, np - 1));
		it.dim = ($urandom_range(0, 15) == 0) ? 5'($urandom) : 5'($urandom_range(0, nd - 1));
		it.init_position = rand_value();
		it.init_velocity = rand_value();
		case ($urandom_range(0, 3))
			0: it.velocity_limit = 31'($urandom);
			1: it.velocity_limit = '1;
			default: it.velocity_limit = 31'($urandom_range(0, 2**20));
		endcase
		it.rand_personal = 16'($urandom);
		it.rand_global = 16'($urandom);
		case ($urandom_range(0, 3))
			0: it.residue = $urandom;
			1: it.residue = pbest_res[it.particle];
			default: it.residue = gbest_res - $signed(32'($urandom_range(0, 2**16)));
		endcase
		return make_legal(it);
	endfunction

	task automatic send_item(item_t it);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.mode;
		s_axis_tdata <= {7'b0, it.residue, it.rand_global, it.rand_personal,
			it.velocity_limit, it.init_velocity, it.init_position, it.dim, it.particle};
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(swarm_step(it));
		mode_count[it.mode]++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_AW'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_PHI_P:     cfg_phi_p = val[15:0];
			REG_PHI_G:     cfg_phi_g = val[15:0];
			REG_KAPPA:     cfg_kappa = val[12:0];
			REG_DIMS:      cfg_dims = val[5:0];
			REG_PARTICLES: cfg_parts = val[5:0];
			REG_THRESHOLD: cfg_thresh = val;
			default: ;
		endcase
	endtask

	task automatic configure(int unsigned pp, int unsigned pg, int unsigned kap,
		int unsigned nd, int unsigned np, int unsigned thr);
		drain();
		write_reg(REG_PHI_P, pp);
		write_reg(REG_PHI_G, pg);
		write_reg(REG_KAPPA, kap);
		write_reg(REG_DIMS, nd);
		write_reg(REG_PARTICLES, np);
		write_reg(REG_THRESHOLD, thr);
	endtask

	function automatic item_t mk(logic [2:0] mode, int p, int d, logic [31:0] pos,
		logic [31:0] vel, logic [30:0] lim, logic [15:0] rp, logic [15:0] rg,
		logic [31:0] r);
		item_t it;
		it.mode = mode;
		it.particle = 5'(p);
		it.dim = 5'(d);
		it.init_position = pos;
		it.init_velocity = vel;
		it.velocity_limit = lim;
		it.rand_personal = rp;
		it.rand_global = rg;
		it.residue = r;
		return it;
	endfunction

	task automatic test_directed();
		configure(16'hFFFF, 16'hFFFF, 4096, 2, 2, 0);
		send_item(mk(MODE_INIT, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, '1, 0, 0, 0));
		send_item(mk(MODE_INIT, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, '0, 0, 0, 0));
		send_item(mk(MODE_INIT, 0, 1, 32'h0001_8000, 32'hFFFF_8000, 31'h0002_0000, 0, 0, 0));
		send_item(mk(MODE_INIT, 1, 1, 32'hFFFE_8000, 32'h0000_0001, 31'h0002_0000, 0, 0, 0));
		send_item(mk(MODE_SPREAD, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(MODE_RESIDUE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(MODE_RESIDUE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(MODE_RESIDUE, 1, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
		send_item(mk(MODE_RESIDUE, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
		send_item(mk(MODE_UPDATE, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0));
		send_item(mk(MODE_UPDATE, 0, 1, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0));
		send_item(mk(MODE_UPDATE, 1, 1, 0, 0, 0, 16'hFFFF, 16'h0000, 0));
		send_item(mk(MODE_UPDATE, 1, 0, 0, 0, 0, 16'h8000, 16'hFFFF, 0));
		send_item(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(MODE_READ, 0, 1, 0, 0, 0, 0, 0, 0));
		send_item(mk(MODE_UPDATE, 31, 0, 0, 0, 0, 1, 1, 0));
		send_item(mk(MODE_READ, 0, 31, 0, 0, 0, 0, 0, 0));
		send_item(mk(MODE_RESIDUE, 2, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
		send_item(mk(3'd5, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(3'd6, 1, 1, 0, 0, 0, 0, 0, 0));
		send_item(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(MODE_INIT, 0, 0, 32'h0000_1000, 0, 31'h100, 0, 0, 0));
		send_item(mk(MODE_RESIDUE, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
		send_item(mk(MODE_SPREAD, 0, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random(int n, bit pressure);
		int i;
		for (i = 0; i < n; i++) begin
			quiet = (i % 97) < 15;
			if (pressure && i == n / 2) drain();
			send_item(rand_item());
		end
		quiet = 1'b0;
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		int n;
		if (m_stall > 0) begin
			m_stall <= m_stall - 1;
			m_axis_tready <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			n = quiet ? 0 : $urandom_range(0, 15);
			m_axis_tready <= (n == 0);
			m_stall <= (n > 0) ? n - 1 : 0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("result with no transaction outstanding");
				mismatches++;
			end else begin
				exp_r = expected_results.pop_front();
				check_field("value_out", exp_r.value_out, $signed(m_axis_tdata[31:0]));
				check_field("global_best_residue", exp_r.global_best_residue,
					$signed(m_axis_tdata[63:32]));
				check_field("improved_personal", exp_r.improved_personal, m_axis_tdata[64]);
				check_field("improved_global", exp_r.improved_global, m_axis_tdata[65]);
				check_field("spread", exp_r.spread, m_axis_tdata[97:66]);
				check_field("converged", exp_r.converged, m_axis_tdata[98]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NP_MAX; i++) pbest_res[i] = RES_MAX;
		gbest_res = RES_MAX;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		configure($urandom_range(0, 65535), $urandom_range(0, 65535), 2989, 4, 4,
			$urandom_range(0, 2**20));
		test_random(200, 1'b0);
		configure(65535, 65535, 8191, 0, 2, 0);
		test_random(100, 1'b0);
		configure(0, 0, 0, 63, 2, 32'hFFFF_FFFF);
		test_random(150, 1'b0);
		configure($urandom_range(0, 65535), $urandom_range(0, 65535), 4096, 8, 6, $urandom);
		test_random(250, 1'b1);
		configure(11469, 5325, $urandom_range(0, 4096), 3, 63, 32'h0004_0000);
		test_random(150, 1'b0);
		drain();
		repeat (50) @(posedge clk);
		$display("Covered init %0d, update %0d, residue %0d, read %0d, spread %0d items,",
			mode_count[0], mode_count[1], mode_count[2], mode_count[3], mode_count[4]);
		$display("plus %0d unknown-mode items over six register settings.",
			mode_count[5] + mode_count[6] + mode_count[7]);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/pse_pkg.sv
hw/rtl/pse_ram.sv
hw/rtl/pse_scale.sv
hw/rtl/pse_core.sv
hw/rtl/particle_swarm_update_engine.sv
hw/rtl/pse_checker.sv
tb/sv/tb_particle_swarm_update_engine.sv
